// File: design/sine_cosine_polynomial_defines.svh
// Assertion macros shared by the sine/cosine pipeline.
`ifndef SINE_COSINE_POLYNOMIAL_DEFINES_SVH
`define SINE_COSINE_POLYNOMIAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clk edge outside reset
`define SCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scp assertion failed");
// Implication with a fixed cycle delay
`define SCP_ASSERT_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("scp delayed assertion failed");
`else
`define SCP_ASSERT_IMP(label, ante, cons)
`define SCP_ASSERT_DLY(label, ante, dly, cons)
`endif
`endif

// File: design/scp_pkg.sv
// Shared types and fixed constants of the sine/cosine pipeline.
package scp_pkg;

  // pi with 60 fraction bits, rounded to nearest
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam int          EXTRA_BITS  = 28;
  localparam int          POLY_FRAC   = 30;
  localparam int          RECIP_SHIFT = 33;

  // Reciprocals for exact floor division of 30-bit values by constants
  localparam int DIV6_SHIFT   = 33;
  localparam int DIV24_SHIFT  = 35;
  localparam int DIV120_SHIFT = 37;
  localparam int DIV720_SHIFT = 40;
  localparam logic [30:0] RECIP_DIV6   = 31'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);
  localparam logic [30:0] RECIP_DIV24  = 31'(((64'd1 << DIV24_SHIFT) + 64'd23) / 64'd24);
  localparam logic [30:0] RECIP_DIV120 = 31'(((64'd1 << DIV120_SHIFT) + 64'd119) / 64'd120);
  localparam logic [30:0] RECIP_DIV720 = 31'(((64'd1 << DIV720_SHIFT) + 64'd719) / 64'd720);

  localparam logic [31:0] POLY_ONE = 32'd1 << POLY_FRAC;

  // Folded argument handed from range reduction to the polynomial
  typedef struct packed {
    logic        valid;
    logic        use_sine;
    logic        neg;
    logic [29:0] arg;
  } scp_arg_t;

  // Polynomial magnitude (Q30) handed to the output stage
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [30:0] mag;
  } scp_mag_t;

endpackage

// File: design/sine_cosine_polynomial.sv
// Each accepted item passes in order through the register stages listed below and
// leaves on out_value with out_valid high.
// Throughput: one item per cycle; the ten register stages never stall.
// Stages: four for range reduction, five for the series, one for round/saturate.
// busy is high only while rst_n is low; no item is taken during reset.
// Reset (synchronous) clears every stage valid bit, dropping items in flight.
`include "sine_cosine_polynomial_defines.svh"
module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS  = 24,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_angle,
  input  logic               in_operation,
  output logic               out_valid,
  output logic signed [17:0] out_value
);

  localparam int LATENCY = 10;

  scp_pkg::scp_arg_t arg;
  scp_pkg::scp_mag_t mag;
  logic              in_valid;

  // items are taken every cycle outside reset
  assign busy     = ~rst_n;
  assign in_valid = start & ~busy;

  scp_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .angle    (in_angle),
    .operation(in_operation),
    .arg_o    (arg)
  );

  scp_poly u_poly (
    .clk  (clk),
    .rst_n(rst_n),
    .arg_i(arg),
    .mag_o(mag)
  );

  scp_round #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .mag_i    (mag),
    .out_valid(out_valid),
    .out_value(out_value)
  );

  // Every accepted item comes out after the full pipeline, and nothing else does
  `SCP_ASSERT_DLY(a_latency_fwd, start && !busy, LATENCY, out_valid)
  `SCP_ASSERT_IMP(a_latency_bwd, out_valid, $past(start && !busy, LATENCY))
  // Sine of a zero angle is exactly zero
  `SCP_ASSERT_DLY(a_sine_of_zero, start && !busy && (in_angle == 32'sd0) && !in_operation, LATENCY, out_value == 18'sd0)

endmodule

// File: design/scp_reduce.sv
// Range reduction: quadrant, sign, octant fold and Q0.30 argument (4 stages).
`include "sine_cosine_polynomial_defines.svh"
module scp_reduce #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] angle,
  input  logic               operation,
  output scp_pkg::scp_arg_t  arg_o
);

  localparam int HPW = ANGLE_FRAC_BITS + 29;        // width of pi/2 in reduction units
  localparam int RW  = HPW + 2;                      // remainder work width
  localparam int KW  = scp_pkg::RECIP_SHIFT - ANGLE_FRAC_BITS;  // reciprocal / quotient width
  localparam int PW1 = scp_pkg::RECIP_SHIFT + KW;   // angle * reciprocal
  localparam int XLW = RW - scp_pkg::EXTRA_BITS;    // angle bits that reach the remainder
  localparam int ASH = ANGLE_FRAC_BITS + scp_pkg::EXTRA_BITS - scp_pkg::POLY_FRAC;

  localparam logic [63:0] HP64 =
    (scp_pkg::PI_Q60 + (64'd1 << (32 - ANGLE_FRAC_BITS))) >> (33 - ANGLE_FRAC_BITS);
  localparam logic [HPW-1:0] HP = HP64[HPW-1:0];
  localparam logic [63:0] K64 =
    (64'd1 << (scp_pkg::RECIP_SHIFT + scp_pkg::EXTRA_BITS)) / HP64;
  localparam logic [KW-1:0] K = K64[KW-1:0];
  localparam logic [29:0] ARG_MAX = 30'(HP >> (ANGLE_FRAC_BITS - 1));

  // Stage 1: quotient estimate angle * (2^61 / hp)
  logic                  v1_r;
  logic [31:0]           x1_r;
  logic                  op1_r;
  logic signed [PW1-1:0] prod_r, prod_nxt;

  assign prod_nxt = $signed({{(KW + 1){angle[31]}}, angle}) *
                    $signed({{(PW1 - KW){1'b0}}, K});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x1_r   <= angle;
    op1_r  <= operation;
    prod_r <= prod_nxt;
  end

  // Stage 2: estimate times hp, low bits only
  logic [KW-1:0] qe;
  logic [RW-1:0] qe_ext;
  logic [RW-1:0] qhp_r, qhp_nxt;
  logic          v2_r;
  logic [31:0]   x2_r;
  logic          op2_r;
  logic [1:0]    q2_r;

  assign qe      = prod_r[PW1-1:scp_pkg::RECIP_SHIFT];
  assign qe_ext  = {{(RW - KW){qe[KW-1]}}, qe};
  assign qhp_nxt = qe_ext * {2'b00, HP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    x2_r  <= x1_r;
    op2_r <= op1_r;
    q2_r  <= qe[1:0];
    qhp_r <= qhp_nxt;
  end

  // Stage 3: remainder and one-step correction of the estimate
  logic [RW-1:0]  xlow;
  logic [RW-1:0]  rem0;
  logic [HPW-1:0] rem_r, rem_nxt;
  logic [1:0]     quad_r, quad_nxt;
  logic           v3_r;
  logic           op3_r;

  assign xlow = {x2_r[XLW-1:0], {scp_pkg::EXTRA_BITS{1'b0}}};
  assign rem0 = xlow - qhp_r;

  always_comb begin
    rem_nxt  = rem0[HPW-1:0];
    quad_nxt = q2_r;
    if (rem0[RW-1]) begin
      rem_nxt  = rem0[HPW-1:0] + HP;
      quad_nxt = q2_r - 2'd1;
    end else if (rem0 >= {2'b00, HP}) begin
      rem_nxt  = rem0[HPW-1:0] - HP;
      quad_nxt = q2_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    rem_r  <= rem_nxt;
    quad_r <= quad_nxt;
  end

  // Stage 4: fold into the first quadrant, pick the octant, scale to Q0.30
  logic [HPW-1:0] diff;
  logic [HPW-1:0] fold;
  logic [HPW-1:0] other;
  logic [HPW-1:0] arg_full;
  logic           low_oct;
  logic           v4_r;
  logic           sine_r, sine_nxt;
  logic           neg_r, neg_nxt;
  logic [29:0]    arg_r;

  assign diff     = HP - rem_r;
  assign fold     = quad_r[0] ? diff : rem_r;
  assign other    = quad_r[0] ? rem_r : diff;
  assign low_oct  = {fold, 1'b0} < {1'b0, HP};
  assign arg_full = low_oct ? fold : other;
  assign sine_nxt = low_oct ? ~op3_r : op3_r;
  // cosine negative in quadrants 1 and 2, sine in 2 and 3
  assign neg_nxt  = op3_r ? (quad_r[1] ^ quad_r[0]) : quad_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
    neg_r  <= neg_nxt;
    arg_r  <= arg_full[ASH +: 30];
  end

  assign arg_o = '{valid: v4_r, use_sine: sine_r, neg: neg_r, arg: arg_r};

  // Reciprocal estimate is off by at most one quadrant
  `SCP_ASSERT_IMP(a_est_within_one, v2_r, ($signed(rem0) >= -$signed({2'b00, HP})) && ($signed(rem0) < $signed({1'b0, HP, 1'b0})))
  // Corrected remainder lies inside one quadrant
  `SCP_ASSERT_IMP(a_rem_in_quadrant, v3_r, rem_r < HP)
  // Folded argument never exceeds pi/4
  `SCP_ASSERT_IMP(a_arg_in_octant, v4_r, arg_r <= ARG_MAX)

endmodule

// File: design/scp_poly.sv
// Taylor polynomial pipeline: powers, constant divisions and final sum (5 stages).
module scp_poly (
  input  logic              clk,
  input  logic              rst_n,
  input  scp_pkg::scp_arg_t arg_i,
  output scp_pkg::scp_mag_t mag_o
);

  // Stage 1: t^2
  logic [59:0] sq_full;
  logic        p1_v_r, p1_s_r, p1_n_r;
  logic [29:0] p1_t_r, p1_sq_r;

  assign sq_full = arg_i.arg * arg_i.arg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= arg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_s_r  <= arg_i.use_sine;
    p1_n_r  <= arg_i.neg;
    p1_t_r  <= arg_i.arg;
    p1_sq_r <= sq_full[59:30];
  end

  // Stage 2: t^3 for sine, t^4 for cosine
  logic [59:0] pw_full;
  logic        p2_v_r, p2_s_r, p2_n_r;
  logic [29:0] p2_t_r, p2_sq_r, p2_pw_r;

  assign pw_full = p1_sq_r * (p1_s_r ? p1_t_r : p1_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_s_r  <= p1_s_r;
    p2_n_r  <= p1_n_r;
    p2_t_r  <= p1_t_r;
    p2_sq_r <= p1_sq_r;
    p2_pw_r <= pw_full[59:30];
  end

  // Stage 3: t^5 or t^6, and t^3/6 or t^4/24
  logic [59:0] hi_full;
  logic [60:0] dm_full;
  logic [27:0] q_nxt;
  logic        p3_v_r, p3_s_r, p3_n_r;
  logic [29:0] p3_t_r, p3_sq_r, p3_hi_r;
  logic [27:0] p3_q_r;

  assign hi_full = p2_sq_r * p2_pw_r;
  assign dm_full = p2_pw_r * (p2_s_r ? scp_pkg::RECIP_DIV6 : scp_pkg::RECIP_DIV24);
  assign q_nxt   = p2_s_r ? dm_full[scp_pkg::DIV6_SHIFT +: 28]
                          : {2'b00, dm_full[scp_pkg::DIV24_SHIFT +: 26]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_s_r  <= p2_s_r;
    p3_n_r  <= p2_n_r;
    p3_t_r  <= p2_t_r;
    p3_sq_r <= p2_sq_r;
    p3_hi_r <= hi_full[59:30];
    p3_q_r  <= q_nxt;
  end

  // Stage 4: t^5/120 or t^6/720
  logic [60:0] em_full;
  logic [23:0] w_nxt;
  logic        p4_v_r, p4_s_r, p4_n_r;
  logic [29:0] p4_t_r, p4_sq_r;
  logic [27:0] p4_q_r;
  logic [23:0] p4_w_r;

  assign em_full = p3_hi_r * (p3_s_r ? scp_pkg::RECIP_DIV120 : scp_pkg::RECIP_DIV720);
  assign w_nxt   = p3_s_r ? em_full[scp_pkg::DIV120_SHIFT +: 24]
                          : {3'b000, em_full[scp_pkg::DIV720_SHIFT +: 21]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else begin
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p4_s_r  <= p3_s_r;
    p4_n_r  <= p3_n_r;
    p4_t_r  <= p3_t_r;
    p4_sq_r <= p3_sq_r;
    p4_q_r  <= p3_q_r;
    p4_w_r  <= w_nxt;
  end

  // Stage 5: sum of the series terms
  logic [31:0] sin_sum, cos_sum;
  logic        p5_v_r, p5_n_r;
  logic [30:0] p5_mag_r;

  assign sin_sum = {2'b00, p4_t_r} - {4'b0000, p4_q_r} + {8'h00, p4_w_r};
  assign cos_sum = scp_pkg::POLY_ONE - {3'b000, p4_sq_r[29:1]} + {4'b0000, p4_q_r}
                   - {8'h00, p4_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else begin
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p5_n_r   <= p4_n_r;
    p5_mag_r <= p4_s_r ? sin_sum[30:0] : cos_sum[30:0];
  end

  assign mag_o = '{valid: p5_v_r, neg: p5_n_r, mag: p5_mag_r};

endmodule

// File: design/scp_round.sv
// Output stage: round to the result format, apply sign, saturate to 18 bits.
module scp_round #(
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scp_pkg::scp_mag_t  mag_i,
  output logic               out_valid,
  output logic signed [17:0] out_value
);

  localparam int          SH        = scp_pkg::POLY_FRAC - RESULT_FRAC_BITS;
  localparam logic [31:0] HALF      = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
  localparam logic [31:0] POS_LIMIT = 32'd131071;
  localparam logic [31:0] NEG_LIMIT = 32'd131072;

  logic [31:0] rnd;
  logic [31:0] lim;
  logic [31:0] lim_neg;
  logic        valid_r;
  logic [17:0] value_r, value_nxt;

  // round half up, then clamp the magnitude before negating
  assign rnd = ({1'b0, mag_i.mag} + HALF) >> SH;

  always_comb begin
    if (mag_i.neg) begin
      lim = (rnd > NEG_LIMIT) ? NEG_LIMIT : rnd;
    end else begin
      lim = (rnd > POS_LIMIT) ? POS_LIMIT : rnd;
    end
  end

  assign lim_neg   = 32'd0 - lim;
  assign value_nxt = mag_i.neg ? lim_neg[17:0] : lim[17:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= mag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign out_valid = valid_r;
  assign out_value = $signed(value_r);

endmodule
